### sv/box_blur_3x3_edge_clipped_macros.svh
// Assertion macros used by the box blur RTL.
`ifndef BOX_BLUR_3X3_EDGE_CLIPPED_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_CLIPPED_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BB_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/boxblur_pkg.sv
// Types, constants and small helpers of the 3x3 box blur.
`timescale 1ns / 1ps
`default_nettype none

package boxblur_pkg;

   localparam int PIX_W      = 8;   // one color channel
   localparam int CHANNELS   = 3;
   localparam int RGB_W      = PIX_W * CHANNELS;
   localparam int SUM_W      = 12;  // 9 * 255 + 4 fits
   localparam int CNT_W      = 4;   // neighbor count 1..9
   localparam int TAPS       = 9;
   localparam int ROW_W      = 16;
   localparam int CFG_W_W    = 11;  // image_width register
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;
   localparam int LEFT_W     = 2;   // results still allowed for the current word
   localparam int DIVB_W     = 3;   // quotient bit index

   localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_READ  = 6'b000100,
      ST_SUM   = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   // Line store bank of the next row, modulo 3.
   function automatic logic [1:0] bank_next(input logic [1:0] b);
      bank_next = (b == 2'd2) ? 2'd0 : b + 2'd1;
   endfunction

   // Line store bank of the previous row, modulo 3.
   function automatic logic [1:0] bank_prev(input logic [1:0] b);
      bank_prev = (b == 2'd0) ? 2'd2 : b - 2'd1;
   endfunction

endpackage

`default_nettype wire

### sv/box_blur_3x3_edge_clipped.sv
// 3x3 box blur over an RGB raster stream, neighborhood clipped at the frame edges.
//
// Usage: configure image_width (csr index 0) and image_height (index 1) while
// idle. Send pixel words (req_operation = pixel) in raster order; each pixel
// word returns up to two blurred results, the oldest whose in-frame neighbors
// have all arrived. After the last pixel, drain words each return one pending
// result (or none). rsp_frame_end marks the result of the frame's last pixel.
// Flow: a word is taken only when the engine is idle. Each result takes nine
// reads of the line store (one write port, one registered read port), one per
// cycle, a step to close the sum, and a bit-serial divide by the neighbor
// count.
// A finished result sits in an output register; the next word is accepted while
// it waits. If the receiver stalls and the engine has a further result, the
// engine holds in its emit step until the register frees.
// Reset (synchronous): positions clear, image 1024 x 1, no result pending.
// The line store is not cleared; it is always written before it is read.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_edge_clipped_macros.svh"

module box_blur_3x3_edge_clipped #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_we,
   input  wire logic [boxblur_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [boxblur_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // input words
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire logic                                  req_operation,
   input  wire logic [boxblur_pkg::PIX_W-1:0]         req_red_in,
   input  wire logic [boxblur_pkg::PIX_W-1:0]         req_green_in,
   input  wire logic [boxblur_pkg::PIX_W-1:0]         req_blue_in,
   // result words
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      logic [boxblur_pkg::PIX_W-1:0]         rsp_red_out,
   output      logic [boxblur_pkg::PIX_W-1:0]         rsp_green_out,
   output      logic [boxblur_pkg::PIX_W-1:0]         rsp_blue_out,
   output      logic                                  rsp_frame_end
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW    = (COL_W + 1 > boxblur_pkg::CFG_W_W) ? COL_W + 1
                                                             : boxblur_pkg::CFG_W_W;
   localparam int DEPTH = 3 * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = boxblur_pkg::ROW_W + 1;
   localparam int PW    = boxblur_pkg::PIX_W;
   localparam int SW    = boxblur_pkg::SUM_W;
   localparam int CW    = boxblur_pkg::CNT_W;
   localparam int NCH   = boxblur_pkg::CHANNELS;
   localparam logic [AW-1:0] BASE1 = AW'(MAX_WIDTH);
   localparam logic [AW-1:0] BASE2 = AW'(2 * MAX_WIDTH);

   // Start address of a bank in the line store.
   function automatic logic [AW-1:0] bank_base(input logic [1:0] b);
      logic [AW-1:0] base;
      base = '0;
      if (b == 2'd1) base = BASE1;
      else if (b == 2'd2) base = BASE2;
      return base;
   endfunction

   // ---------------------------------------------------------------- state
   logic [boxblur_pkg::CFG_W_W-1:0]  width_ff, width_in;
   logic [boxblur_pkg::ROW_W-1:0]    height_ff, height_in;
   boxblur_pkg::state_type           state_ff, state_in;
   logic [boxblur_pkg::LEFT_W-1:0]   left_ff, left_in;
   logic [boxblur_pkg::ROW_W-1:0]    in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [COL_W-1:0]                 in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [1:0]                       in_bank_ff, in_bank_in, out_bank_ff, out_bank_in;
   logic                             in_done_ff, in_done_in;
   logic [1:0]                       tap_r_ff, tap_r_in, tap_c_ff, tap_c_in;
   logic [CW-1:0]                    cnt_ff, cnt_in;
   logic                             rd_use_ff, rd_use_in;
   logic [SW-1:0]                    acc_ff [NCH];
   logic [SW-1:0]                    acc_in [NCH];
   logic [PW-1:0]                    quo_ff [NCH];
   logic [PW-1:0]                    quo_in [NCH];
   logic [boxblur_pkg::DIVB_W-1:0]   div_bit_ff, div_bit_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                    rsp_red_ff, rsp_red_in;
   logic [PW-1:0]                    rsp_green_ff, rsp_green_in;
   logic [PW-1:0]                    rsp_blue_ff, rsp_blue_in;
   logic                             rsp_end_ff, rsp_end_in;

   // line store
   logic [boxblur_pkg::RGB_W-1:0]    store_mem [DEPTH];
   logic [boxblur_pkg::RGB_W-1:0]    rd_data_ff;
   logic [AW-1:0]                    rd_addr, wr_addr;
   logic                             wr_en;
   logic [boxblur_pkg::RGB_W-1:0]    wr_data;

   // ------------------------------------------------------ frame geometry
   logic [EW-1:0]                    eff_w;
   logic [boxblur_pkg::ROW_W-1:0]    eff_h;
   logic                             in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
   logic [RW-1:0]                    out_row_p1;
   logic [EW-1:0]                    out_col_p1;
   logic [boxblur_pkg::ROW_W-1:0]    next_row;
   logic [EW-1:0]                    next_col;
   logic                             before_cur, before_next, res_ready;

   always_comb begin
      eff_w = EW'(width_ff);
      if (width_ff == '0) eff_w = EW'(1);
      else if (EW'(width_ff) > EW'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
      eff_h = (height_ff == '0) ? boxblur_pkg::ROW_W'(1) : height_ff;

      in_col_wrap  = (EW'(in_col_ff) + EW'(1)) >= eff_w;
      in_row_wrap  = (RW'(in_row_ff) + RW'(1)) >= RW'(eff_h);
      out_col_p1   = EW'(out_col_ff) + EW'(1);
      out_row_p1   = RW'(out_row_ff) + RW'(1);
      out_col_wrap = out_col_p1 >= eff_w;
      out_row_wrap = out_row_p1 >= RW'(eff_h);

      // a result is ready once its last in-frame neighbor has arrived
      next_row = (out_row_p1 < RW'(eff_h)) ? out_row_p1[boxblur_pkg::ROW_W-1:0]
                                           : eff_h - boxblur_pkg::ROW_W'(1);
      next_col = (out_col_p1 < eff_w) ? out_col_p1 : eff_w - EW'(1);
      before_cur  = (out_row_ff < in_row_ff) ||
                    ((out_row_ff == in_row_ff) && (out_col_ff < in_col_ff));
      before_next = (next_row < in_row_ff) ||
                    ((next_row == in_row_ff) && (next_col < EW'(in_col_ff)));
      res_ready   = in_done_ff || (before_cur && before_next);
   end

   // --------------------------------------------------------- tap address
   logic [RW-1:0]  tap_row_sum;
   logic [EW-1:0]  tap_col_sum;
   logic [EW-1:0]  tap_col_m1;
   logic           tap_centre, tap_out, tap_use;
   logic [1:0]     tap_bank;

   always_comb begin
      // row = out_row + tap_r - 1, column likewise; sums kept offset by one
      tap_row_sum = RW'(out_row_ff) + RW'(tap_r_ff);
      tap_col_sum = EW'(out_col_ff) + EW'(tap_c_ff);
      tap_col_m1  = tap_col_sum - EW'(1);
      tap_centre  = (tap_r_ff == 2'd1) && (tap_c_ff == 2'd1);
      tap_out     = (tap_row_sum == '0) || (tap_row_sum > RW'(eff_h)) ||
                    (tap_col_sum == '0) || (tap_col_sum > eff_w);
      tap_use     = tap_centre || !tap_out;
      case (tap_r_ff)
         2'd0:    tap_bank = boxblur_pkg::bank_prev(out_bank_ff);
         2'd2:    tap_bank = boxblur_pkg::bank_next(out_bank_ff);
         default: tap_bank = out_bank_ff;
      endcase
      rd_addr = bank_base(tap_bank) + AW'(tap_col_m1[COL_W-1:0]);
   end

   // --------------------------------------------------------- handshakes
   logic req_fire, emit_fire;

   assign req_ready = (state_ff == boxblur_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign emit_fire = (state_ff == boxblur_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign wr_en   = req_fire && (req_operation == boxblur_pkg::OP_PIXEL);
   assign wr_addr = bank_base(in_bank_ff) + AW'(in_col_ff);
   assign wr_data = {req_red_in, req_green_in, req_blue_in};

   // ------------------------------------------------------- config write
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (boxblur_pkg::csr_index_type'(csr_addr))
            boxblur_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata[boxblur_pkg::CFG_W_W-1:0];
            boxblur_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------- sequencer
   logic [SW-1:0] div_trial;
   logic [SW-1:0] half_cnt;
   logic [PW-1:0] pix;

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      in_bank_in   = in_bank_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_bank_in  = out_bank_ff;
      in_done_in   = in_done_ff;
      tap_r_in     = tap_r_ff;
      tap_c_in     = tap_c_ff;
      cnt_in       = cnt_ff;
      div_bit_in   = div_bit_ff;
      rd_use_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_end_in   = rsp_end_ff;
      half_cnt     = SW'(cnt_ff >> 1);
      div_trial    = SW'(cnt_ff) << div_bit_ff;
      for (int ch = 0; ch < NCH; ch++) begin
         acc_in[ch] = acc_ff[ch];
         quo_in[ch] = quo_ff[ch];
      end

      // accumulate the word read in the previous cycle
      for (int ch = 0; ch < NCH; ch++) begin
         pix = rd_data_ff[(NCH - 1 - ch) * PW +: PW];
         if (rd_use_ff) acc_in[ch] = acc_ff[ch] + SW'(pix);
         if (state_ff == boxblur_pkg::ST_SUM) acc_in[ch] = acc_in[ch] + half_cnt;
      end

      unique case (state_ff)
         boxblur_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_operation == boxblur_pkg::OP_PIXEL) begin
                  // a new pixel after a complete frame drops what is pending
                  if (in_done_ff) begin
                     in_done_in  = 1'b0;
                     out_row_in  = '0;
                     out_col_in  = '0;
                     out_bank_in = 2'd0;
                  end
                  if (in_col_wrap) begin
                     in_col_in = '0;
                     if (in_row_wrap) begin
                        in_row_in  = '0;
                        in_bank_in = 2'd0;
                        in_done_in = 1'b1;
                     end else begin
                        in_row_in  = in_row_ff + boxblur_pkg::ROW_W'(1);
                        in_bank_in = boxblur_pkg::bank_next(in_bank_ff);
                     end
                  end else begin
                     in_col_in = in_col_ff + COL_W'(1);
                  end
                  left_in = boxblur_pkg::LEFT_W'(2);
               end else begin
                  left_in = boxblur_pkg::LEFT_W'(1);
               end
               state_in = boxblur_pkg::ST_CHECK;
            end
         end
         boxblur_pkg::ST_CHECK: begin
            if ((left_ff != '0) && res_ready) begin
               tap_r_in = 2'd0;
               tap_c_in = 2'd0;
               cnt_in   = '0;
               for (int ch = 0; ch < NCH; ch++) acc_in[ch] = '0;
               state_in = boxblur_pkg::ST_READ;
            end else begin
               state_in = boxblur_pkg::ST_IDLE;
            end
         end
         boxblur_pkg::ST_READ: begin
            // one neighbor read per cycle, row by row
            rd_use_in = tap_use;
            if (tap_use) cnt_in = cnt_ff + CW'(1);
            if (tap_c_ff == 2'd2) begin
               tap_c_in = 2'd0;
               tap_r_in = tap_r_ff + 2'd1;
               if (tap_r_ff == 2'd2) state_in = boxblur_pkg::ST_SUM;
            end else begin
               tap_c_in = tap_c_ff + 2'd1;
            end
         end
         boxblur_pkg::ST_SUM: begin
            div_bit_in = '1;
            state_in   = boxblur_pkg::ST_DIV;
         end
         boxblur_pkg::ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            for (int ch = 0; ch < NCH; ch++) begin
               if (acc_ff[ch] >= div_trial) begin
                  acc_in[ch] = acc_ff[ch] - div_trial;
                  quo_in[ch] = {quo_ff[ch][PW-2:0], 1'b1};
               end else begin
                  quo_in[ch] = {quo_ff[ch][PW-2:0], 1'b0};
               end
            end
            div_bit_in = div_bit_ff - boxblur_pkg::DIVB_W'(1);
            if (div_bit_ff == '0) state_in = boxblur_pkg::ST_EMIT;
         end
         boxblur_pkg::ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = quo_ff[0];
               rsp_green_in = quo_ff[1];
               rsp_blue_in  = quo_ff[2];
               rsp_end_in   = 1'b0;
               if (out_col_wrap) begin
                  out_col_in = '0;
                  if (out_row_wrap) begin
                     out_row_in  = '0;
                     out_bank_in = 2'd0;
                     in_done_in  = 1'b0;
                     rsp_end_in  = 1'b1;
                  end else begin
                     out_row_in  = out_row_ff + boxblur_pkg::ROW_W'(1);
                     out_bank_in = boxblur_pkg::bank_next(out_bank_ff);
                  end
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
               left_in  = left_ff - boxblur_pkg::LEFT_W'(1);
               state_in = boxblur_pkg::ST_CHECK;
            end
         end
         default: state_in = boxblur_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= boxblur_pkg::WIDTH_RESET;
         height_ff    <= boxblur_pkg::HEIGHT_RESET;
         state_ff     <= boxblur_pkg::ST_IDLE;
         left_ff      <= '0;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_bank_ff   <= 2'd0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_bank_ff  <= 2'd0;
         in_done_ff   <= 1'b0;
         rd_use_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         state_ff     <= state_in;
         left_ff      <= left_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_bank_ff   <= in_bank_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         out_bank_ff  <= out_bank_in;
         in_done_ff   <= in_done_in;
         rd_use_ff    <= rd_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      tap_r_ff     <= tap_r_in;
      tap_c_ff     <= tap_c_in;
      cnt_ff       <= cnt_in;
      div_bit_ff   <= div_bit_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_end_ff   <= rsp_end_in;
      for (int ch = 0; ch < NCH; ch++) begin
         acc_ff[ch] <= acc_in[ch];
         quo_ff[ch] <= quo_in[ch];
      end
   end

   // line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
      rd_data_ff <= store_mem[rd_addr];
   end

   // ------------------------------------------------------------ outputs
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out  = rsp_blue_ff;
   assign rsp_frame_end = rsp_end_ff;

   // --------------------------------------------------------- assertions
   `BB_ASSERT(a_div_count, state_ff == boxblur_pkg::ST_DIV, (cnt_ff != '0) && (cnt_ff <= CW'(boxblur_pkg::TAPS)), "neighbor count out of range in divide")
   `BB_ASSERT(a_bank_range, 1'b1, (in_bank_ff != 2'd3) && (out_bank_ff != 2'd3), "line store bank out of range")
   `BB_ASSERT(a_left_range, state_ff != boxblur_pkg::ST_IDLE, left_ff <= boxblur_pkg::LEFT_W'(2), "more than two results pending for one word")
   `BB_ASSERT_NEXT(a_emit_hold, (state_ff == boxblur_pkg::ST_EMIT) && rsp_valid_ff && !rsp_ready, state_ff == boxblur_pkg::ST_EMIT, "result overwrote a stalled output word")
   `BB_ASSERT_NEXT(a_accept_check, req_fire, state_ff == boxblur_pkg::ST_CHECK, "accepted word not followed by readiness check")

endmodule

`default_nettype wire
